// ===== rtl/wrt_pkg.sv =====
// ----------------------------------------------------------------------------
// wrt_pkg: shared types and constants for the wildcard reward table
// Request and response payload structs, mode codes, probe count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wrt_pkg;

  localparam int STATE_KEY_W  = 4;
  localparam int ACTION_KEY_W = 3;
  localparam int REWARD_W     = 32;

  // probes per lookup: every subset of {state, action, next state} wildcarded
  localparam int PATTERN_COUNT = 8;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [STATE_KEY_W-1:0]     state_key;
    logic [ACTION_KEY_W-1:0]    action_key;
    logic [STATE_KEY_W-1:0]     next_state_key;
    logic signed [REWARD_W-1:0] reward_in;
  } req_t;

  typedef struct packed {
    logic signed [REWARD_W-1:0] reward_out;
    logic                       hit;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/wildcard_reward_table.sv =====
// ----------------------------------------------------------------------------
// wildcard_reward_table
// Reward table keyed by (state, action, next state) with wildcard fallback.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                    | Payload       | Transfer
//  --------+----------------------------+---------------+---------------------
//  request | req_valid, req_stall, req  | wrt_pkg::req_t| req_valid & !req_stall
//  result  | rsp_valid, rsp_stall, rsp  | wrt_pkg::rsp_t| rsp_valid & !rsp_stall
//
//  Write: lands in the entry memory at its transfer. Lookup: req_stall stays
//    high until ST_DONE hands the result to the result register and returns
//    to ST_IDLE; the single-port entry memory serves one probe read per cycle
//    and up to eight probes are needed.
//  Clear: one entry invalidated per cycle, all DEPTH entries in turn.
//  After reset the same clearing pass runs over all DEPTH entries (2048 with the
//    default parameters) with req_stall high.
//  A waiting result does not block writes or clears; a finished lookup
//    holds in its last state until the result register is free.
//
`timescale 1ns / 1ps
`default_nettype none

module wildcard_reward_table #(
  parameter int STATE_COUNT  = 15,
  parameter int ACTION_COUNT = 7,
  parameter int REWARD_BITS  = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire wrt_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output wrt_pkg::rsp_t      rsp
);

  localparam int S_W    = $clog2(STATE_COUNT + 1);
  localparam int A_W    = $clog2(ACTION_COUNT + 1);
  localparam int DEPTH  = (STATE_COUNT + 1) * (ACTION_COUNT + 1) * (STATE_COUNT + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CALC_W = ADDR_W + 4;
  localparam int CNT_W  = $clog2(wrt_pkg::PATTERN_COUNT + 1);

  localparam logic [S_W-1:0]    S_WILD    = S_W'(STATE_COUNT);
  localparam logic [A_W-1:0]    A_WILD    = A_W'(ACTION_COUNT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  PROBE_END = CNT_W'(wrt_pkg::PATTERN_COUNT);
  localparam logic [2:0]        LAST_PAT  = 3'(wrt_pkg::PATTERN_COUNT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_DONE  = 4'b1000
  } fsm_t;

  function automatic logic [S_W-1:0] clamp_s(input logic [wrt_pkg::STATE_KEY_W-1:0] k);
    logic [CALC_W-1:0] kx;
    kx = CALC_W'(k);
    if (kx > CALC_W'(STATE_COUNT)) kx = CALC_W'(STATE_COUNT);
    return S_W'(kx);
  endfunction

  function automatic logic [A_W-1:0] clamp_a(input logic [wrt_pkg::ACTION_KEY_W-1:0] k);
    logic [CALC_W-1:0] kx;
    kx = CALC_W'(k);
    if (kx > CALC_W'(ACTION_COUNT)) kx = CALC_W'(ACTION_COUNT);
    return A_W'(kx);
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [S_W-1:0] s,
                                                   input logic [A_W-1:0] a,
                                                   input logic [S_W-1:0] n);
    logic [CALC_W-1:0] row;
    row = CALC_W'(s) * CALC_W'(ACTION_COUNT + 1) + CALC_W'(a);
    row = row * CALC_W'(STATE_COUNT + 1) + CALC_W'(n);
    return ADDR_W'(row);
  endfunction

  // entry = {valid, reward}
  logic [REWARD_BITS:0] mem [DEPTH];
  logic [REWARD_BITS:0] mem_rdata;
  logic [REWARD_BITS:0] mem_wdata;
  logic [ADDR_W-1:0]    mem_addr;
  logic                 mem_we;
  logic                 mem_re;

  fsm_t               state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [CNT_W-1:0]   probe_cnt;
  logic               chk_valid;
  logic [2:0]         chk_pat;
  logic [S_W-1:0]     key_s;
  logic [A_W-1:0]     key_a;
  logic [S_W-1:0]     key_n;
  logic signed [wrt_pkg::REWARD_W-1:0] res_reward;
  logic               res_hit;

  logic                          accept;
  logic                          rsp_free;
  logic [REWARD_BITS-1:0]        wr_reward;
  logic signed [wrt_pkg::REWARD_W-1:0] rd_reward;
  logic [2:0]                    pat;
  logic [S_W-1:0]                pat_s;
  logic [A_W-1:0]                pat_a;
  logic [S_W-1:0]                pat_n;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // store-width conversion on write, back to 32 bits on read
  if (REWARD_BITS < wrt_pkg::REWARD_W) begin : g_narrow
    localparam logic signed [wrt_pkg::REWARD_W-1:0] SAT_HI =
      wrt_pkg::REWARD_W'((longint'(1) <<< (REWARD_BITS - 1)) - 1);
    localparam logic signed [wrt_pkg::REWARD_W-1:0] SAT_LO = -SAT_HI - 1;
    always_comb begin
      if (req.reward_in > SAT_HI) begin
        wr_reward = REWARD_BITS'(SAT_HI);
      end else if (req.reward_in < SAT_LO) begin
        wr_reward = REWARD_BITS'(SAT_LO);
      end else begin
        wr_reward = REWARD_BITS'(req.reward_in);
      end
    end
    assign rd_reward = wrt_pkg::REWARD_W'($signed(mem_rdata[REWARD_BITS-1:0]));
  end else begin : g_wide
    assign wr_reward = REWARD_BITS'(req.reward_in);
    assign rd_reward = $signed(mem_rdata[wrt_pkg::REWARD_W-1:0]);
  end

  // probe pattern: bit 0 state, bit 1 action, bit 2 next state
  assign pat   = probe_cnt[2:0];
  assign pat_s = pat[0] ? S_WILD : key_s;
  assign pat_a = pat[1] ? A_WILD : key_a;
  assign pat_n = pat[2] ? S_WILD : key_n;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    case (state)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      ST_IDLE: begin
        if (accept && req.mode == wrt_pkg::MODE_WRITE) begin
          mem_we    = 1'b1;
          mem_addr  = entry_addr(clamp_s(req.state_key), clamp_a(req.action_key),
                                 clamp_s(req.next_state_key));
          mem_wdata = {1'b1, wr_reward};
        end
      end
      ST_PROBE: begin
        if (probe_cnt < PROBE_END) begin
          mem_re   = 1'b1;
          mem_addr = entry_addr(pat_s, pat_a, pat_n);
        end
      end
      default: ;
    endcase
  end

  // a write lands at the edge it is accepted, so later probes see it
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      probe_cnt <= '0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // a completing lookup reloads the result register in ST_DONE instead
      if (rsp_valid && !rsp_stall && state != ST_DONE) rsp_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) state <= ST_IDLE;
        end
        ST_IDLE: begin
          chk_valid <= 1'b0;
          if (accept) begin
            case (req.mode)
              wrt_pkg::MODE_CLEAR: begin
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              wrt_pkg::MODE_LOOKUP: begin
                probe_cnt <= '0;
                state     <= ST_PROBE;
              end
              default: ;
            endcase
          end
        end
        ST_PROBE: begin
          probe_cnt <= probe_cnt + CNT_W'(mem_re);
          chk_valid <= mem_re;
          // read data of the previous probe is checked here; first valid wins
          if (chk_valid && (mem_rdata[REWARD_BITS] || chk_pat == LAST_PAT)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      key_s <= clamp_s(req.state_key);
      key_a <= clamp_a(req.action_key);
      key_n <= clamp_s(req.next_state_key);
    end
    if (state == ST_PROBE) chk_pat <= pat;
    if (state == ST_PROBE && chk_valid) begin
      res_hit    <= mem_rdata[REWARD_BITS];
      res_reward <= mem_rdata[REWARD_BITS] ? rd_reward : '0;
    end
    if (state == ST_DONE && rsp_free) begin
      rsp.reward_out <= res_reward;
      rsp.hit        <= res_hit;
    end
  end

  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("entry memory written and read in the same cycle");

  a_lookup_start: assert property (@(posedge clk) disable iff (rst)
    accept && req.mode == wrt_pkg::MODE_LOOKUP |=> state == ST_PROBE && probe_cnt == '0)
    else $error("lookup did not start at the first probe");

  a_check_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_PROBE && chk_valid |-> chk_pat == 3'(probe_cnt - 1'b1))
    else $error("checked probe is not the one issued last");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the lookup completion");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_PROBE |-> probe_cnt <= PROBE_END)
    else $error("probe counter past the last pattern");

endmodule

`default_nettype wire
